// ===== design/ata_pkg.sv =====
`timescale 1ns / 1ps
// ata_pkg: shared constants for the tilt angle core
// atan table in q2.30 radians and output scaling limits

package ata_pkg;

  localparam int TableSize = 24;
  localparam int RadMax    = 25736;
  localparam int DegMax    = 11520;
  localparam int DegScale  = 3754936;
  localparam int RadWidth  = 16;
  localparam int DegWidth  = 15;
  localparam int ZWidth    = 33;

  typedef enum logic [0:0] {
    REG_INVERT_ROLL  = 1'b0,
    REG_INVERT_PITCH = 1'b1
  } cfg_reg_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    begin
      case (idx)
        5'd0:  v = 30'h3243F6A8;
        5'd1:  v = 30'h1DAC6705;
        5'd2:  v = 30'h0FADBAFC;
        5'd3:  v = 30'h07F56EA6;
        5'd4:  v = 30'h03FEAB76;
        5'd5:  v = 30'h01FFD55B;
        5'd6:  v = 30'h00FFFAAA;
        5'd7:  v = 30'h007FFF55;
        5'd8:  v = 30'h003FFFEA;
        5'd9:  v = 30'h001FFFFD;
        5'd10: v = 30'h000FFFFF;
        5'd11: v = 30'h0007FFFF;
        5'd12: v = 30'h0003FFFF;
        5'd13: v = 30'h0001FFFF;
        5'd14: v = 30'h0000FFFF;
        5'd15: v = 30'h00007FFF;
        5'd16: v = 30'h00003FFF;
        5'd17: v = 30'h00001FFF;
        5'd18: v = 30'h00000FFF;
        5'd19: v = 30'h000007FF;
        5'd20: v = 30'h000003FF;
        5'd21: v = 30'h000001FF;
        5'd22: v = 30'h000000FF;
        5'd23: v = 30'h0000007F;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

// ===== design/ata_sqrt.sv =====
`timescale 1ns / 1ps
// ata_sqrt: pipelined floor integer square root, one result bit per stage
// depends on nothing; stage advance is driven by the top level

module ata_sqrt #(
  parameter int IN_WIDTH  = 32,
  parameter int OUT_WIDTH = 16,
  parameter int TAG_WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [IN_WIDTH-1:0]  radicand,
  input  logic [TAG_WIDTH-1:0] in_tag,
  output logic                 out_valid,
  output logic [OUT_WIDTH-1:0] root,
  output logic [TAG_WIDTH-1:0] out_tag
);

  localparam int RW = 2 * OUT_WIDTH;

  logic                 vld [1:OUT_WIDTH];
  logic [RW-1:0]        rem [1:OUT_WIDTH];
  logic [OUT_WIDTH-1:0] rt  [1:OUT_WIDTH];
  logic [TAG_WIDTH-1:0] tag [1:OUT_WIDTH];

  for (genvar s = 0; s < OUT_WIDTH; s++) begin : g_stage
    localparam int B = OUT_WIDTH - 1 - s;
    logic                 vld_cur;
    logic [RW-1:0]        rem_cur;
    logic [OUT_WIDTH-1:0] rt_cur;
    logic [TAG_WIDTH-1:0] tag_cur;
    logic [RW-1:0] trial;
    logic [RW-1:0] rem_next;
    logic [OUT_WIDTH-1:0] rt_next;
    if (s == 0) begin : g_head
      assign vld_cur = in_valid;
      assign rem_cur = RW'(radicand);
      assign rt_cur  = '0;
      assign tag_cur = in_tag;
    end else begin : g_body
      assign vld_cur = vld[s];
      assign rem_cur = rem[s];
      assign rt_cur  = rt[s];
      assign tag_cur = tag[s];
    end
    always_comb begin
      trial = (RW'(rt_cur) << (B + 1)) | (RW'(1) << (2 * B));
      if (rem_cur >= trial) begin
        rem_next = rem_cur - trial;
        rt_next  = rt_cur | (OUT_WIDTH'(1) << B);
      end else begin
        rem_next = rem_cur;
        rt_next  = rt_cur;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= vld_cur;
      end
      if (adv) begin
        rem[s+1] <= rem_next;
        rt[s+1]  <= rt_next;
        tag[s+1] <= tag_cur;
      end
    end
  end

  assign out_valid = vld[OUT_WIDTH];
  assign root      = rt[OUT_WIDTH];
  assign out_tag   = tag[OUT_WIDTH];

endmodule

// ===== design/ata_cordic.sv =====
`timescale 1ns / 1ps
// ata_cordic: pipelined cordic vectoring, one micro-rotation per stage
// depends on ata_pkg for the arctangent table

module ata_cordic #(
  parameter int XY_WIDTH   = 34,
  parameter int ITERATIONS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic signed [XY_WIDTH-1:0] x_in,
  input  logic signed [XY_WIDTH-1:0] y_in,
  input  logic                       zero_in,
  output logic                       out_valid,
  output logic signed [ata_pkg::ZWidth-1:0] z_out,
  output logic                       zero_out
);

  import ata_pkg::*;

  localparam int N = (ITERATIONS < TableSize) ? ITERATIONS : TableSize;

  logic                       vld [1:N];
  logic signed [XY_WIDTH-1:0] xs  [1:N];
  logic signed [XY_WIDTH-1:0] ys  [1:N];
  logic signed [ZWidth-1:0]   zs  [1:N];
  logic                       zf  [1:N];

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic                       vld_cur, zf_cur;
    logic signed [XY_WIDTH-1:0] x_cur, y_cur;
    logic signed [ZWidth-1:0]   z_cur;
    logic signed [XY_WIDTH-1:0] xsh, ysh, x_next, y_next;
    logic signed [ZWidth-1:0] z_next, ang;
    if (i == 0) begin : g_head
      assign vld_cur = in_valid;
      assign x_cur   = x_in;
      assign y_cur   = y_in;
      assign z_cur   = '0;
      assign zf_cur  = zero_in;
    end else begin : g_body
      assign vld_cur = vld[i];
      assign x_cur   = xs[i];
      assign y_cur   = ys[i];
      assign z_cur   = zs[i];
      assign zf_cur  = zf[i];
    end
    always_comb begin
      xsh = x_cur >>> i;
      ysh = y_cur >>> i;
      ang = ZWidth'(atan_q30(5'(i)));
      if (!y_cur[XY_WIDTH-1]) begin
        x_next = x_cur + ysh;
        y_next = y_cur - xsh;
        z_next = z_cur + ang;
      end else begin
        x_next = x_cur - ysh;
        y_next = y_cur + xsh;
        z_next = z_cur - ang;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= vld_cur;
      end
      if (adv) begin
        xs[i+1] <= x_next;
        ys[i+1] <= y_next;
        zs[i+1] <= z_next;
        zf[i+1] <= zf_cur;
      end
    end
  end

  assign out_valid = vld[N];
  assign z_out     = zs[N];
  assign zero_out  = zf[N];

endmodule

// ===== design/accel_tilt_angle_core.sv =====
`timescale 1ns / 1ps
// accel_tilt_angle_core: accelerometer tilt angle, atan2 of one axis over the
// root of the sum of squares of the other two, in radians and degrees
// pipeline: select and square, sum of squares, the one-bit-per-stage root and
// the one-rotation-per-stage cordic pipelines, then the scale and output stages
// throughput: one word per cycle; a stall on the output holds the whole pipe
// reset: sync active-high rst clears all valid bits and both invert registers

module accel_tilt_angle_core #(
  parameter int SAMPLE_WIDTH     = 16,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic                           cfg_index,
  input  logic                           cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           mode,
  input  logic signed [SAMPLE_WIDTH-1:0] roll_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] pitch_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] vertical_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [ata_pkg::RadWidth-1:0] angle_rad,
  output logic signed [ata_pkg::DegWidth-1:0] angle_deg
);

  import ata_pkg::*;

  localparam int NW  = SAMPLE_WIDTH + 1;
  localparam int SQW = 2 * SAMPLE_WIDTH;
  localparam int XYW = NW + 14 + 3;
  localparam int MW  = ZWidth + 23;

  logic invert_roll, invert_pitch;
  logic adv;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      invert_roll  <= 1'b0;
      invert_pitch <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_INVERT_ROLL:  invert_roll  <= cfg_data;
        REG_INVERT_PITCH: invert_pitch <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: select and square
  logic                   s1_valid;
  logic signed [NW-1:0]   s1_n;
  logic [SQW-1:0]         s1_sqa, s1_sqv;
  logic signed [NW-1:0]   num_sel;
  logic signed [SAMPLE_WIDTH-1:0] oth_sel;

  always_comb begin
    if (mode) begin
      num_sel = invert_pitch ? -NW'(pitch_sample) : NW'(pitch_sample);
      oth_sel = roll_sample;
    end else begin
      num_sel = invert_roll ? -NW'(roll_sample) : NW'(roll_sample);
      oth_sel = pitch_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
    if (adv) begin
      s1_n   <= num_sel;
      s1_sqa <= SQW'(oth_sel * oth_sel);
      s1_sqv <= SQW'(vertical_sample * vertical_sample);
    end
  end

  // stage 2: sum of squares
  logic                 s2_valid;
  logic signed [NW-1:0] s2_n;
  logic [SQW:0]         s2_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
    if (adv) begin
      s2_n   <= s1_n;
      s2_sum <= (SQW+1)'(s1_sqa) + (SQW+1)'(s1_sqv);
    end
  end

  logic                  sq_valid;
  logic [SAMPLE_WIDTH:0] sq_root;
  logic [NW-1:0]         sq_tag;

  ata_sqrt #(
    .IN_WIDTH  (SQW + 1),
    .OUT_WIDTH (SAMPLE_WIDTH + 1),
    .TAG_WIDTH (NW)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s2_valid),
    .radicand  (s2_sum),
    .in_tag    (s2_n),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_tag   (sq_tag)
  );

  logic signed [XYW-1:0] x0, y0;
  logic                  zz0;
  always_comb begin
    x0  = $signed({{(XYW-NW-14){1'b0}}, sq_root, 14'b0});
    y0  = $signed({{(XYW-NW-14){sq_tag[NW-1]}}, sq_tag, 14'b0});
    zz0 = (sq_root == '0) && (sq_tag == '0);
  end

  logic                     co_valid, co_zero;
  logic signed [ZWidth-1:0] co_z;

  ata_cordic #(
    .XY_WIDTH   (XYW),
    .ITERATIONS (ANGLE_ITERATIONS)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sq_valid),
    .x_in      (x0),
    .y_in      (y0),
    .zero_in   (zz0),
    .out_valid (co_valid),
    .z_out     (co_z),
    .zero_out  (co_zero)
  );

  // scale stage: degree product and radian rounding
  logic                     sc_valid, sc_zero;
  logic signed [MW-1:0]     sc_prod;
  logic signed [ZWidth-1:0] sc_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_valid <= 1'b0;
    end else if (adv) begin
      sc_valid <= co_valid;
    end
    if (adv) begin
      sc_zero <= co_zero;
      sc_prod <= MW'(co_z) * MW'(DegScale);
      sc_rad  <= (co_z + ZWidth'(32768)) >>> 16;
    end
  end

  // output stage: round degrees and saturate
  logic signed [MW-1:0]       deg_full;
  logic signed [RadWidth-1:0] rad_sat;
  logic signed [DegWidth-1:0] deg_sat;

  always_comb begin
    deg_full = (sc_prod + (MW'(1) <<< 38)) >>> 39;
    if (sc_rad > ZWidth'(RadMax)) begin
      rad_sat = RadWidth'(RadMax);
    end else if (sc_rad < -ZWidth'(RadMax)) begin
      rad_sat = -RadWidth'(RadMax);
    end else begin
      rad_sat = RadWidth'(sc_rad);
    end
    if (deg_full > MW'(DegMax)) begin
      deg_sat = DegWidth'(DegMax);
    end else if (deg_full < -MW'(DegMax)) begin
      deg_sat = -DegWidth'(DegMax);
    end else begin
      deg_sat = DegWidth'(deg_full);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= sc_valid;
    end
    if (adv) begin
      angle_rad <= sc_zero ? '0 : rad_sat;
      angle_deg <= sc_zero ? '0 : deg_sat;
    end
  end

endmodule
